FILE: design/blr_pkg.sv
// Shared constants, codes and types of the line rasteriser.
package blr_pkg;

    localparam int COORD_BITS  = 11;
    localparam int STRIDE_BITS = 12;
    localparam int ADDR_BITS   = 22;
    localparam int COLOR_BITS  = 32;
    localparam int DTERM_BITS  = COORD_BITS + 3;
    localparam int PROD_BITS   = COORD_BITS + STRIDE_BITS;

    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(640);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic [STRIDE_BITS-1:0]        stride_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [COLOR_BITS-1:0]         color_t;
    typedef logic signed [DTERM_BITS-1:0]  dterm_t;

    typedef struct packed {
        logic   command;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } cmd_t;

    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        addr_t  pixel_address;
        color_t pixel_color;
        logic   last_pixel;
    } pix_t;

endpackage

FILE: design/blr_cmd_if.sv
// Command channel interface: line loads and pixel requests.
interface blr_cmd_if;
    logic               valid;
    logic               ready;
    logic               command;
    blr_pkg::coord_t    start_x;
    blr_pkg::coord_t    start_y;
    blr_pkg::coord_t    end_x;
    blr_pkg::coord_t    end_y;
    blr_pkg::color_t    line_color;

    modport source (output valid, command, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

FILE: design/blr_pix_if.sv
// Pixel channel interface: one rasterised pixel per transaction.
interface blr_pix_if;
    logic               valid;
    logic               ready;
    logic               pixel_valid;
    blr_pkg::coord_t    pixel_x;
    blr_pkg::coord_t    pixel_y;
    blr_pkg::addr_t     pixel_address;
    blr_pkg::color_t    pixel_color;
    logic               last_pixel;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                    pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                    pixel_color, last_pixel, output ready);
endinterface

FILE: design/blr_cfg_if.sv
// Configuration write channel interface carrying the row stride.
interface blr_cfg_if;
    logic               valid;
    logic               ready;
    blr_pkg::stride_t   line_stride;

    modport source (output valid, line_stride, input ready);
    modport sink   (input valid, line_stride, output ready);
endinterface

FILE: design/blr_step.sv
// Line set-up, Bresenham stepping and pixel address generation.
module blr_step
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  blr_pkg::cmd_t    cmd,
    input  blr_pkg::stride_t stride,
    output logic             push,
    output blr_pkg::pix_t    result
);

    localparam int DPAD = blr_pkg::DTERM_BITS - blr_pkg::COORD_BITS;

    logic             line_active_reg, line_active_next;
    logic             x_is_major_reg, x_is_major_next;
    blr_pkg::coord_t  cur_x_reg, cur_x_next;
    blr_pkg::coord_t  cur_y_reg, cur_y_next;
    blr_pkg::coord_t  major_end_reg, major_end_next;
    blr_pkg::dterm_t  decision_term_reg, decision_term_next;
    blr_pkg::coord_t  major_delta_reg, major_delta_next;
    blr_pkg::coord_t  minor_delta_reg, minor_delta_next;
    logic             minor_neg_reg, minor_neg_next;
    blr_pkg::color_t  held_color_reg, held_color_next;

    logic signed [blr_pkg::COORD_BITS:0] dx;
    logic signed [blr_pkg::COORD_BITS:0] dy;
    logic signed [blr_pkg::COORD_BITS:0] adx_w;
    logic signed [blr_pkg::COORD_BITS:0] ady_w;
    blr_pkg::coord_t  adx;
    blr_pkg::coord_t  ady;
    logic             ld_x_major;
    logic             swap_ends;
    blr_pkg::coord_t  ld_major;
    blr_pkg::coord_t  ld_minor;
    blr_pkg::coord_t  major_now;
    logic             last;
    logic [blr_pkg::PROD_BITS-1:0] product;
    blr_pkg::dterm_t  minor_ext;
    blr_pkg::dterm_t  major_ext;
    blr_pkg::coord_t  minor_stepped_y;
    blr_pkg::coord_t  minor_stepped_x;

    always_comb
    begin
        dx         = $signed({1'b0, cmd.end_x}) - $signed({1'b0, cmd.start_x});
        dy         = $signed({1'b0, cmd.end_y}) - $signed({1'b0, cmd.start_y});
        adx_w      = dx[blr_pkg::COORD_BITS] ? -dx : dx;
        ady_w      = dy[blr_pkg::COORD_BITS] ? -dy : dy;
        adx        = adx_w[blr_pkg::COORD_BITS-1:0];
        ady        = ady_w[blr_pkg::COORD_BITS-1:0];
        ld_x_major = adx > ady;
        swap_ends  = ld_x_major ? dx[blr_pkg::COORD_BITS] : dy[blr_pkg::COORD_BITS];
        ld_major   = ld_x_major ? adx : ady;
        ld_minor   = ld_x_major ? ady : adx;

        major_now  = x_is_major_reg ? cur_x_reg : cur_y_reg;
        last       = major_now == major_end_reg;
        product    = blr_pkg::PROD_BITS'(cur_y_reg) * blr_pkg::PROD_BITS'(stride);
        minor_ext  = blr_pkg::dterm_t'({{DPAD{1'b0}}, minor_delta_reg});
        major_ext  = blr_pkg::dterm_t'({{DPAD{1'b0}}, major_delta_reg});
        minor_stepped_y = minor_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        minor_stepped_x = minor_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;

        result               = '0;
        if (line_active_reg)
        begin
            result.pixel_valid   = 1'b1;
            result.pixel_x       = cur_x_reg;
            result.pixel_y       = cur_y_reg;
            result.pixel_address = blr_pkg::ADDR_BITS'(product
                                   + blr_pkg::PROD_BITS'(cur_x_reg));
            result.pixel_color   = held_color_reg;
            result.last_pixel    = last;
        end
        push = fire && (cmd.command == blr_pkg::CMD_STEP);

        line_active_next   = line_active_reg;
        x_is_major_next    = x_is_major_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        major_end_next     = major_end_reg;
        decision_term_next = decision_term_reg;
        major_delta_next   = major_delta_reg;
        minor_delta_next   = minor_delta_reg;
        minor_neg_next     = minor_neg_reg;
        held_color_next    = held_color_reg;

        if (fire && (cmd.command == blr_pkg::CMD_LOAD))
        begin
            minor_neg_next     = !((dx > 0 && dy > 0) || (dx < 0 && dy < 0));
            x_is_major_next    = ld_x_major;
            major_delta_next   = ld_major;
            minor_delta_next   = ld_minor;
            if (ld_x_major)
                major_end_next = swap_ends ? cmd.start_x : cmd.end_x;
            else
                major_end_next = swap_ends ? cmd.start_y : cmd.end_y;
            cur_x_next         = swap_ends ? cmd.end_x : cmd.start_x;
            cur_y_next         = swap_ends ? cmd.end_y : cmd.start_y;
            decision_term_next = blr_pkg::dterm_t'({{(DPAD-1){1'b0}}, ld_minor, 1'b0})
                                 - blr_pkg::dterm_t'({{DPAD{1'b0}}, ld_major});
            held_color_next    = cmd.line_color;
            line_active_next   = 1'b1;
        end
        else if (push && line_active_reg)
        begin
            if (last)
                line_active_next = 1'b0;
            else
            begin
                if (x_is_major_reg)
                    cur_x_next = cur_x_reg + 1'b1;
                else
                    cur_y_next = cur_y_reg + 1'b1;
                if (decision_term_reg < 0)
                    decision_term_next = decision_term_reg + (minor_ext <<< 1);
                else
                begin
                    if (x_is_major_reg)
                        cur_y_next = minor_stepped_y;
                    else
                        cur_x_next = minor_stepped_x;
                    decision_term_next = decision_term_reg
                                         + ((minor_ext - major_ext) <<< 1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg   <= 1'b0;
            x_is_major_reg    <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            major_end_reg     <= '0;
            decision_term_reg <= '0;
            major_delta_reg   <= '0;
            minor_delta_reg   <= '0;
            minor_neg_reg     <= 1'b0;
            held_color_reg    <= '0;
        end
        else
        begin
            line_active_reg   <= line_active_next;
            x_is_major_reg    <= x_is_major_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            major_end_reg     <= major_end_next;
            decision_term_reg <= decision_term_next;
            major_delta_reg   <= major_delta_next;
            minor_delta_reg   <= minor_delta_next;
            minor_neg_reg     <= minor_neg_next;
            held_color_reg    <= held_color_next;
        end
    end

`ifndef SYNTHESIS
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (push && line_active_reg && last) |=> !line_active_reg)
        else $error("line still active after its final pixel");

    a_load_starts_line: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.command == blr_pkg::CMD_LOAD) |=> line_active_reg)
        else $error("load did not start a line");

    a_major_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (push && line_active_reg && !last && x_is_major_reg)
        |=> cur_x_reg == $past(cur_x_reg) + 1'b1)
        else $error("major coordinate did not advance by one");

    a_idle_result_blank: assert property (@(posedge clk) disable iff (!rst_n)
        !line_active_reg |-> result == '0)
        else $error("idle result is not blank");
`endif

endmodule

FILE: design/blr_out_buf.sv
// Two-entry output buffer that decouples pixel generation from the receiver.
module blr_out_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  blr_pkg::pix_t push_data,
    output logic          full,
    blr_pix_if.source     pix
);

    blr_pkg::pix_t buf_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          pop;
    blr_pkg::pix_t head;

    always_comb
    begin
        full        = count_reg == 2'd2;
        pop         = pix.valid && pix.ready;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        head        = buf_reg[rd_ptr_reg];

        pix.valid         = count_reg != 2'd0;
        pix.pixel_valid   = head.pixel_valid;
        pix.pixel_x       = head.pixel_x;
        pix.pixel_y       = head.pixel_y;
        pix.pixel_address = head.pixel_address;
        pix.pixel_color   = head.pixel_color;
        pix.last_pixel    = head.last_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full output buffer");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("output buffer pointers disagree with count");
`endif

endmodule

FILE: design/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasteriser.
// A transaction on cmd with command = 0 loads a line: two endpoints and a
// colour. It gives no pixel. A transaction with command = 1 requests the next
// pixel of the active line; it gives exactly one transaction on pix, carrying
// x, y, colour, the word offset y * stride + x (modulo 2^22) and last_pixel on
// the final pixel. A request while no line is active gives a pix transaction
// with every field zero, pixel_valid included.
// cfg writes the row stride; cfg is always ready and the stride applies to
// requests accepted after the write.
// A requested pixel is written into the output buffer and offered on pix
// from there. Throughput: one cmd transaction per cycle while the buffer is
// not full; each step is one add and compare plus an 11 x 12 multiply for
// the address, all between the line state registers and the output buffer.
// When pix stalls, the buffer holds up to two pixels and cmd stays ready until
// it is full, so a load can still be taken behind a waiting pixel.
// Reset: no line active, stride 640, output buffer empty.
module bresenham_line_rasterizer
(
    input  logic      clk,
    input  logic      rst_n,
    blr_cmd_if.sink   cmd,
    blr_cfg_if.sink   cfg,
    blr_pix_if.source pix
);

    blr_pkg::stride_t stride_reg;
    blr_pkg::cmd_t    cmd_data;
    blr_pkg::pix_t    result;
    logic             fire;
    logic             push;
    logic             full;

    always_comb
    begin
        cmd.ready           = !full;
        cfg.ready           = 1'b1;
        fire                = cmd.valid && cmd.ready;
        cmd_data.command    = cmd.command;
        cmd_data.start_x    = cmd.start_x;
        cmd_data.start_y    = cmd.start_y;
        cmd_data.end_x      = cmd.end_x;
        cmd_data.end_y      = cmd.end_y;
        cmd_data.line_color = cmd.line_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= blr_pkg::STRIDE_RESET;
        else if (cfg.valid && cfg.ready)
            stride_reg <= cfg.line_stride;
    end

    blr_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (cmd_data),
        .stride (stride_reg),
        .push   (push),
        .result (result)
    );

    blr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (full),
        .pix       (pix)
    );

endmodule

FILE: tb/sv/blr_pixel_scoreboard.sv
// Scoreboard of the line rasteriser: predicts each pixel transaction and compares it.
`timescale 1ns / 100ps

module blr_pixel_scoreboard
    import blr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    blr_cmd_if   cmd_mon,
    blr_cfg_if   cfg_mon,
    blr_pix_if   pix_mon,
    output int   failures,
    output int   pending
);

    stride_t row_stride;
    logic    line_live;
    logic    x_major;
    logic    minor_down;
    coord_t  pos_x;
    coord_t  pos_y;
    coord_t  major_stop;
    int      decision;
    int      major_span;
    int      minor_span;
    color_t  ink;
    pix_t    expected_pixels[$];
    int      mismatch_count;

    function automatic void latch_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                       color_t col);
        int   dx;
        int   dy;
        int   adx;
        int   ady;
        logic swap_ends;
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        minor_down = !((dx > 0 && dy > 0) || (dx < 0 && dy < 0));
        if (adx > ady)
        begin
            x_major    = 1'b1;
            swap_ends  = (dx < 0);
            major_span = adx;
            minor_span = ady;
            major_stop = swap_ends ? sx : ex;
        end
        else
        begin
            x_major    = 1'b0;
            swap_ends  = (dy < 0);
            major_span = ady;
            minor_span = adx;
            major_stop = swap_ends ? sy : ey;
        end
        pos_x     = swap_ends ? ex : sx;
        pos_y     = swap_ends ? ey : sy;
        decision  = 2 * minor_span - major_span;
        ink       = col;
        line_live = 1'b1;
    endfunction

    function automatic pix_t advance_pixel();
        pix_t p;
        p = '0;
        if (!line_live)
            return p;
        p.pixel_valid   = 1'b1;
        p.pixel_x       = pos_x;
        p.pixel_y       = pos_y;
        p.pixel_address = addr_t'(34'(pos_y) * 34'(row_stride) + 34'(pos_x));
        p.pixel_color   = ink;
        p.last_pixel    = ((x_major ? pos_x : pos_y) == major_stop);
        if (p.last_pixel)
        begin
            line_live = 1'b0;
            return p;
        end
        if (x_major)
            pos_x = pos_x + 1'b1;
        else
            pos_y = pos_y + 1'b1;
        if (decision < 0)
            decision += 2 * minor_span;
        else
        begin
            if (x_major)
                pos_y = minor_down ? pos_y - 1'b1 : pos_y + 1'b1;
            else
                pos_x = minor_down ? pos_x - 1'b1 : pos_x + 1'b1;
            decision += 2 * (minor_span - major_span);
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pix_t seen;
        pix_t want;
        if (!rst_n)
        begin
            row_stride     = STRIDE_RESET;
            line_live      = 1'b0;
            x_major        = 1'b0;
            minor_down     = 1'b0;
            pos_x          = '0;
            pos_y          = '0;
            major_stop     = '0;
            decision       = 0;
            major_span     = 0;
            minor_span     = 0;
            ink            = '0;
            mismatch_count = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
                row_stride = cfg_mon.line_stride;
            if (pix_mon.valid && pix_mon.ready)
            begin
                seen.pixel_valid   = pix_mon.pixel_valid;
                seen.pixel_x       = pix_mon.pixel_x;
                seen.pixel_y       = pix_mon.pixel_y;
                seen.pixel_address = pix_mon.pixel_address;
                seen.pixel_color   = pix_mon.pixel_color;
                seen.last_pixel    = pix_mon.last_pixel;
                if (expected_pixels.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected pixel: v=%0b x=%0d y=%0d addr=%0d col=%h last=%0b",
                                 seen.pixel_valid, seen.pixel_x, seen.pixel_y,
                                 seen.pixel_address, seen.pixel_color, seen.last_pixel);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.pixel_valid !== want.pixel_valid
                        || seen.pixel_x !== want.pixel_x
                        || seen.pixel_y !== want.pixel_y
                        || seen.pixel_address !== want.pixel_address
                        || seen.pixel_color !== want.pixel_color
                        || seen.last_pixel !== want.last_pixel)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("pixel expected: v=%0b x=%0d y=%0d addr=%0d col=%h last=%0b",
                                     want.pixel_valid, want.pixel_x, want.pixel_y,
                                     want.pixel_address, want.pixel_color, want.last_pixel);
                            $display("pixel actual:   v=%0b x=%0d y=%0d addr=%0d col=%h last=%0b",
                                     seen.pixel_valid, seen.pixel_x, seen.pixel_y,
                                     seen.pixel_address, seen.pixel_color, seen.last_pixel);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                if (cmd_mon.command == CMD_LOAD)
                    latch_line(cmd_mon.start_x, cmd_mon.start_y, cmd_mon.end_x,
                               cmd_mon.end_y, cmd_mon.line_color);
                else
                    expected_pixels.push_back(advance_pixel());
            end
        end
        failures <= mismatch_count;
        pending  <= expected_pixels.size();
    end

endmodule

FILE: tb/sv/bresenham_line_rasterizer_tb.sv
// Testbench top of the line rasteriser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module bresenham_line_rasterizer_tb;
    import blr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        steady;
    int          fail_count;
    int          pixel_backlog;
    int unsigned cycle_count = 0;

    blr_cmd_if cmd_ch ();
    blr_cfg_if cfg_ch ();
    blr_pix_if pix_ch ();

    bresenham_line_rasterizer uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch),
        .pix   (pix_ch)
    );

    blr_pixel_scoreboard pixel_sb
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_mon  (cmd_ch),
        .cfg_mon  (cfg_ch),
        .pix_mon  (pix_ch),
        .failures (fail_count),
        .pending  (pixel_backlog)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
        pix_ch.ready <= steady || ($urandom_range(99) >= 11);

    task automatic offer_command(input cmd_t item);
        while (!steady && $urandom_range(99) < 11)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= item.command;
        cmd_ch.start_x    <= item.start_x;
        cmd_ch.start_y    <= item.start_y;
        cmd_ch.end_x      <= item.end_x;
        cmd_ch.end_y      <= item.end_y;
        cmd_ch.line_color <= item.line_color;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic request_pixels(input int count);
        cmd_t item;
        repeat (count)
        begin
            item.command    = CMD_STEP;
            item.start_x    = coord_t'($urandom);
            item.start_y    = coord_t'($urandom);
            item.end_x      = coord_t'($urandom);
            item.end_y      = coord_t'($urandom);
            item.line_color = $urandom;
            offer_command(item);
        end
    endtask

    task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input color_t col, input int count);
        cmd_t item;
        item.command    = CMD_LOAD;
        item.start_x    = sx;
        item.start_y    = sy;
        item.end_x      = ex;
        item.end_y      = ey;
        item.line_color = col;
        offer_command(item);
        request_pixels(count);
    endtask

    task automatic write_stride(input stride_t value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.line_stride <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pixel_backlog != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic coord_t coord_near(input coord_t base, input int span);
        int v;
        v = int'(base) - span + int'($urandom_range(2 * span));
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return coord_t'(v);
    endfunction

    task automatic run_directed();
        request_pixels(1);
        draw_line(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0), 32'h0000_0000, 1);
        draw_line(coord_t'(2047), coord_t'(2047), coord_t'(2047), coord_t'(2047),
                  32'hFFFF_FFFF, 2);
        draw_line(coord_t'(5), coord_t'(0), coord_t'(0), coord_t'(2), 32'h1234_5678, 6);
        draw_line(coord_t'(0), coord_t'(3), coord_t'(1), coord_t'(0), 32'h8000_0001, 4);
        draw_line(coord_t'(2047), coord_t'(0), coord_t'(0), coord_t'(2047),
                  32'hA5A5_5A5A, 2);
        draw_line(coord_t'(3), coord_t'(3), coord_t'(0), coord_t'(0), 32'h0F0F_F0F0, 4);
    endtask

    task automatic run_random_lines(input int budget);
        int     sent;
        int     pick;
        int     span;
        int     dx;
        int     dy;
        int     pixels;
        int     count;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            sx   = coord_t'($urandom);
            sy   = coord_t'($urandom);
            if (pick < 6)
            begin
                ex    = coord_t'($urandom);
                ey    = coord_t'($urandom);
                count = $urandom_range(1, 12);
            end
            else
            begin
                span = (pick < 12) ? 200 : 15;
                ex   = coord_near(sx, span);
                ey   = coord_near(sy, span);
                if (pick >= 12 && pick < 20)
                    ey = sy;
                else if (pick >= 20 && pick < 28)
                    ex = sx;
                else if (pick >= 28 && pick < 32)
                begin
                    ex = sx;
                    ey = sy;
                end
                dx     = int'(ex) - int'(sx);
                dy     = int'(ey) - int'(sy);
                dx     = (dx < 0) ? -dx : dx;
                dy     = (dy < 0) ? -dy : dy;
                pixels = ((dx > dy) ? dx : dy) + 1;
                pick   = $urandom_range(99);
                if (pick < 10)
                    count = $urandom_range(pixels - 1);
                else if (pick >= 90)
                    count = pixels + $urandom_range(1, 3);
                else
                    count = pixels;
            end
            draw_line(sx, sy, ex, ey, $urandom, count);
            sent += count + 1;
        end
    endtask

    initial
    begin
        stride_t stride_pick;
        rst_n              = 1'b0;
        steady             = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_LOAD;
        cmd_ch.start_x     = '0;
        cmd_ch.start_y     = '0;
        cmd_ch.end_x       = '0;
        cmd_ch.end_y       = '0;
        cmd_ch.line_color  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.line_stride = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            steady = (phase == 3);
            case (phase)
                0:       stride_pick = STRIDE_RESET;
                1:       stride_pick = '0;
                2:       stride_pick = '1;
                3:       stride_pick = stride_t'(1);
                4:       stride_pick = stride_t'(2048);
                5:       stride_pick = stride_t'($urandom_range(1, 2048));
                default: stride_pick = stride_t'($urandom);
            endcase
            write_stride(stride_pick);
            if (phase == 0)
                run_directed();
            run_random_lines(PHASE_ITEMS);
            settle();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pixel_backlog == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
